// ===== sv/integer_to_padded_ascii_core_macros.svh =====
// Assertion macros shared by the checker of the ASCII integer formatter.
// No dependencies; pulled in by the checker with an include.
`ifndef INTEGER_TO_PADDED_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_PADDED_ASCII_CORE_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ITPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ITPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/itpa_pkg.sv =====
// Shared constants and types of the ASCII integer formatter.
// No dependencies; imported by every RTL module.
package itpa_pkg;

    localparam int ITPA_VALUE_BITS = 32;
    localparam int ITPA_MAX_WIDTH  = 63;

    localparam int RADIX_BITS    = 6;
    localparam int FW_BITS       = 6;
    localparam int FLAG_BITS     = 4;
    localparam int IN_FIELD_BITS = RADIX_BITS + 1 + FW_BITS + 3;
    localparam int CHAR_BITS     = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_BITS-1:0] DEC_BASE  = 6'd10;

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic negative;
        logic left_adjust;
        logic pad_zero;
        logic upper_case;
    } itpa_fmt_t;

endpackage

// ===== sv/itpa_div.sv =====
// Bit-serial radix divider: peels digits off the value, least significant first.
// Depends on itpa_pkg; feeds digit writes to itpa_emit.
module itpa_div
    import itpa_pkg::*;
#(
    parameter int VALUE_BITS = ITPA_VALUE_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [VALUE_BITS-1:0]                value,
    input  logic [RADIX_BITS-1:0]                radix,
    output logic                                 done,
    output logic [$clog2(VALUE_BITS+1)-1:0]      dig_cnt,
    output logic                                 dig_we,
    output logic [$clog2(VALUE_BITS)-1:0]        dig_addr,
    output logic [RADIX_BITS-1:0]                dig_val
);

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int BIT_W  = $clog2(VALUE_BITS);

    logic                  run_reg,   run_next;
    logic                  done_reg,  done_next;
    logic [VALUE_BITS-1:0] quot_reg,  quot_next;
    logic [RADIX_BITS-1:0] rem_reg,   rem_next;
    logic [RADIX_BITS-1:0] radix_reg, radix_next;
    logic [BIT_W-1:0]      bit_reg,   bit_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;

    logic [RADIX_BITS:0]   trial;
    logic                  ge;
    logic [RADIX_BITS-1:0] rem_step;
    logic [VALUE_BITS-1:0] quot_step;
    logic                  last_bit;
    logic                  stop;

    always_comb
    begin
        // one restoring step: bring in the next dividend bit
        trial     = {rem_reg, quot_reg[VALUE_BITS-1]};
        ge        = trial >= {1'b0, radix_reg};
        rem_step  = ge ? RADIX_BITS'(trial - {1'b0, radix_reg}) : trial[RADIX_BITS-1:0];
        quot_step = {quot_reg[VALUE_BITS-2:0], ge};
        last_bit  = bit_reg == BIT_W'(VALUE_BITS - 1);
        stop      = (quot_step == '0) || (cnt_reg == CNT_W'(VALUE_BITS - 1));

        run_next   = run_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        dig_we     = 1'b0;

        if (start)
        begin
            run_next   = 1'b1;
            quot_next  = value;
            rem_next   = '0;
            radix_next = radix;
            bit_next   = '0;
            cnt_next   = '0;
        end
        else if (run_reg)
        begin
            quot_next = quot_step;
            if (last_bit)
            begin
                dig_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                rem_next = '0;
                bit_next = '0;
                if (stop)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                rem_next = rem_step;
                bit_next = bit_reg + 1'b1;
            end
        end
    end

    assign dig_addr = cnt_reg[ADDR_W-1:0];
    assign dig_val  = rem_step;
    assign dig_cnt  = cnt_reg;
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            bit_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            quot_reg <= quot_next;
            cnt_reg  <= cnt_next;
            bit_reg  <= bit_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
    end

endmodule

// ===== sv/itpa_emit.sv =====
// Character sequencer: digit store, field layout and the output register.
// Depends on itpa_pkg; takes digit writes from itpa_div.
module itpa_emit
    import itpa_pkg::*;
#(
    parameter int VALUE_BITS = ITPA_VALUE_BITS,
    parameter int MAX_WIDTH  = ITPA_MAX_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  itpa_fmt_t                            fmt,
    input  logic [$clog2(((MAX_WIDTH > VALUE_BITS) ? MAX_WIDTH : VALUE_BITS + 1) + 1)-1:0]
                                                 wsat,
    input  logic [$clog2(VALUE_BITS+1)-1:0]      dig_cnt,
    input  logic                                 dig_we,
    input  logic [$clog2(VALUE_BITS)-1:0]        dig_addr,
    input  logic [RADIX_BITS-1:0]                dig_val,
    output logic                                 done,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [CHAR_BITS-1:0]                 m_axis_tdata,   // out_char
    output logic                                 m_axis_tlast    // last_char
);

    localparam int LEN_W  = $clog2(((MAX_WIDTH > VALUE_BITS) ? MAX_WIDTH : VALUE_BITS + 1) + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_ISSUE = 2'd1;
    localparam logic [1:0] E_LOAD  = 2'd2;

    localparam logic [1:0] KIND_DIG   = 2'd0;
    localparam logic [1:0] KIND_SIGN  = 2'd1;
    localparam logic [1:0] KIND_SPACE = 2'd2;
    localparam logic [1:0] KIND_ZERO  = 2'd3;

    logic [RADIX_BITS-1:0] mem [VALUE_BITS];

    logic [1:0]            st_reg,    st_next;
    logic [LEN_W-1:0]      k_reg,     k_next;
    logic [LEN_W-1:0]      actual_reg, total_reg, pad_reg, end_reg;
    logic [1:0]            kind_reg;
    logic                  last_reg;
    logic [RADIX_BITS-1:0] rdata_reg;
    logic                  ov_reg,    ov_next;
    logic [CHAR_BITS-1:0]  och_reg;
    logic                  olast_reg;

    logic [LEN_W-1:0]      actual_c, total_c;
    logic [1:0]            kind_c;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CHAR_BITS-1:0]  char_c;
    logic                  out_free;

    always_comb
    begin
        actual_c = LEN_W'(dig_cnt) + LEN_W'(fmt.negative);
        total_c  = (wsat > actual_c) ? wsat : actual_c;
    end

    // kind of the character at position k of the field
    always_comb
    begin
        if (fmt.left_adjust)
        begin
            if (fmt.negative && k_reg == '0)
                kind_c = KIND_SIGN;
            else if (k_reg < actual_reg)
                kind_c = KIND_DIG;
            else
                kind_c = KIND_SPACE;
        end
        else if (fmt.negative && fmt.pad_zero)
        begin
            if (k_reg == '0)
                kind_c = KIND_SIGN;
            else if (k_reg <= pad_reg)
                kind_c = KIND_ZERO;
            else
                kind_c = KIND_DIG;
        end
        else
        begin
            if (k_reg < pad_reg)
                kind_c = fmt.pad_zero ? KIND_ZERO : KIND_SPACE;
            else if (fmt.negative && k_reg == pad_reg)
                kind_c = KIND_SIGN;
            else
                kind_c = KIND_DIG;
        end
        // digits run most significant first and end at position end_reg - 1
        rd_addr = ADDR_W'(end_reg - k_reg - 1'b1);
    end

    always_comb
    begin
        case (kind_reg)
            KIND_DIG:
            begin
                if (rdata_reg < DEC_BASE)
                    char_c = CH_ZERO + CHAR_BITS'(rdata_reg);
                else
                    char_c = (fmt.upper_case ? CH_UP_A : CH_LO_A)
                             + CHAR_BITS'(rdata_reg - DEC_BASE);
            end
            KIND_SIGN:  char_c = CH_MINUS;
            KIND_ZERO:  char_c = CH_ZERO;
            default:    char_c = CH_SPACE;
        endcase
    end

    assign out_free = !ov_reg || m_axis_tready;

    always_comb
    begin
        st_next = st_reg;
        k_next  = k_reg;
        ov_next = ov_reg && !m_axis_tready;
        done    = 1'b0;
        unique case (st_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    st_next = E_ISSUE;
                    k_next  = '0;
                end
            end
            E_ISSUE:
            begin
                st_next = E_LOAD;
                k_next  = k_reg + 1'b1;
            end
            E_LOAD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    st_next = last_reg ? E_IDLE : E_ISSUE;
                    done    = last_reg;
                end
            end
            default:
            begin
                st_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= E_IDLE;
            ov_reg <= 1'b0;
            k_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            k_reg  <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
            mem[dig_addr] <= dig_val;
        if (st_reg == E_ISSUE)
        begin
            rdata_reg <= mem[rd_addr];
            kind_reg  <= kind_c;
            last_reg  <= k_reg == LEN_W'(total_reg - 1'b1);
        end
        if (st_reg == E_IDLE && start)
        begin
            actual_reg <= actual_c;
            total_reg  <= total_c;
            pad_reg    <= total_c - actual_c;
            end_reg    <= fmt.left_adjust ? actual_c : total_c;
        end
        if (st_reg == E_LOAD && out_free)
        begin
            och_reg   <= char_c;
            olast_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = och_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// ===== sv/integer_to_padded_ascii_core.sv =====
// Integer to padded ASCII formatter, top level. Uses itpa_pkg, itpa_div, itpa_emit.
// The bit-serial divider yields the digits one quotient bit per cycle; the emitter
// then issues and loads each character into the output register, holding while the
// sink stalls. A new request is taken only once the item's last character is loaded.
// Reset: rst_n async, active low; clears control, output beat invalid, input ready.
module integer_to_padded_ascii_core
    import itpa_pkg::*;
#(
    parameter int VALUE_BITS = ITPA_VALUE_BITS,
    parameter int MAX_WIDTH  = ITPA_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // value, radix, negative, field_width, left_adjust, pad_zero, upper_case, zero fill
    input  logic [((VALUE_BITS + IN_FIELD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CHAR_BITS-1:0] m_axis_tdata,   // out_char
    output logic                 m_axis_tlast    // last_char
);

    localparam int LEN_W  = $clog2(((MAX_WIDTH > VALUE_BITS) ? MAX_WIDTH : VALUE_BITS + 1) + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);

    // field offsets inside s_axis_tdata
    localparam int OFS_RADIX = VALUE_BITS;
    localparam int OFS_NEG   = OFS_RADIX + RADIX_BITS;
    localparam int OFS_FW    = OFS_NEG + 1;
    localparam int OFS_LEFT  = OFS_FW + FW_BITS;
    localparam int OFS_ZP    = OFS_LEFT + 1;
    localparam int OFS_UP    = OFS_ZP + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            st_reg, st_next;
    itpa_fmt_t             fmt_reg;
    logic [LEN_W-1:0]      wsat_reg;

    logic                  accept;
    logic [RADIX_BITS-1:0] radix_in, radix_clamp;
    logic [FW_BITS-1:0]    fw_in;
    logic [FW_BITS:0]      fw_sat;

    logic                  div_done;
    logic [CNT_W-1:0]      dig_cnt;
    logic                  dig_we;
    logic [ADDR_W-1:0]     dig_addr;
    logic [RADIX_BITS-1:0] dig_val;
    logic                  emit_done;

    assign s_axis_tready = st_reg == ST_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        radix_in = s_axis_tdata[OFS_RADIX +: RADIX_BITS];
        // out-of-range radix pins to the nearest legal base
        if (radix_in < RADIX_MIN)
            radix_clamp = RADIX_MIN;
        else if (radix_in > RADIX_MAX)
            radix_clamp = RADIX_MAX;
        else
            radix_clamp = radix_in;

        // field width saturates at MAX_WIDTH
        fw_in  = s_axis_tdata[OFS_FW +: FW_BITS];
        fw_sat = ({1'b0, fw_in} > (FW_BITS + 1)'(MAX_WIDTH)) ? (FW_BITS + 1)'(MAX_WIDTH)
                                                             : {1'b0, fw_in};
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (accept)    st_next = ST_DIV;
            ST_DIV:  if (div_done)  st_next = ST_EMIT;
            ST_EMIT: if (emit_done) st_next = ST_IDLE;
            default:                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    // format controls hold for the whole item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg.negative    <= s_axis_tdata[OFS_NEG];
            fmt_reg.left_adjust <= s_axis_tdata[OFS_LEFT];
            fmt_reg.pad_zero    <= s_axis_tdata[OFS_ZP];
            fmt_reg.upper_case  <= s_axis_tdata[OFS_UP];
            wsat_reg            <= LEN_W'(fw_sat);
        end
    end

    itpa_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .value    (s_axis_tdata[VALUE_BITS-1:0]),
        .radix    (radix_clamp),
        .done     (div_done),
        .dig_cnt  (dig_cnt),
        .dig_we   (dig_we),
        .dig_addr (dig_addr),
        .dig_val  (dig_val)
    );

    itpa_emit #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_done),
        .fmt           (fmt_reg),
        .wsat          (wsat_reg),
        .dig_cnt       (dig_cnt),
        .dig_we        (dig_we),
        .dig_addr      (dig_addr),
        .dig_val       (dig_val),
        .done          (emit_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/itpa_checker.sv =====
// Port-level checks of the ASCII integer formatter, bound to the top level.
// Depends on integer_to_padded_ascii_core_macros.svh.
`include "integer_to_padded_ascii_core_macros.svh"

module itpa_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    logic       s_beat;
    logic       m_end;
    logic [1:0] pend_reg;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_end  = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    // items taken in whose last beat has not gone out yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_reg + {1'b0, s_beat} - {1'b0, m_end};
    end

    `ITPA_ASSERT(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output beat dropped while stalled")
    `ITPA_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !m_axis_tvalid, "output valid during reset")
    `ITPA_ASSERT(a_busy_after_in, clk, rst_n, s_beat |=> !s_axis_tready, "input taken while an item is in work")
    `ITPA_ASSERT(a_last_has_item, clk, rst_n, m_end |-> (pend_reg != 2'd0), "last beat without an item")

endmodule

bind integer_to_padded_ascii_core itpa_checker u_itpa_checker (.*);

// ===== sim/ascii_field_checker.sv =====
// Character-stream checker for the integer to padded ASCII formatter.
// Watches both stream channels, predicts each formatted field and compares it.
// Depends on itpa_pkg for character codes and radix limits.
module ascii_field_checker
    import itpa_pkg::*;
#(
    parameter int DATA_W = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [CHAR_BITS-1:0] m_axis_tdata,
    input  logic                 m_axis_tlast,
    output int                   error_count,
    output int                   pending_chars,
    output int                   chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = ITPA_VALUE_BITS;

    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } char_beat_t;

    char_beat_t expected_chars[$];
    int mismatches = 0;
    int checked    = 0;
    int waiting    = 0;

    assign error_count   = mismatches;
    assign pending_chars = waiting;
    assign chars_checked = checked;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input int d, input logic upper);
        if (d < int'(DEC_BASE))
            return CHAR_BITS'(int'(CH_ZERO) + d);
        return CHAR_BITS'(int'(upper ? CH_UP_A : CH_LO_A) + d - int'(DEC_BASE));
    endfunction

    // Expand one request beat into the characters of its field.
    function automatic void format_field(input logic [DATA_W-1:0] beat);
        logic [VB-1:0]        quot;
        logic [CHAR_BITS-1:0] digits [0:VB];
        logic [CHAR_BITS-1:0] field_chars[$];
        itpa_fmt_t            fmt;
        int                   base;
        int                   width;
        int                   ndig;
        int                   total;
        int                   pad;
        int                   k;
        base            = int'(beat[VB +: RADIX_BITS]);
        fmt.negative    = beat[VB + RADIX_BITS];
        width           = int'(beat[VB + RADIX_BITS + 1 +: FW_BITS]);
        fmt.left_adjust = beat[VB + RADIX_BITS + 1 + FW_BITS];
        fmt.pad_zero    = beat[VB + RADIX_BITS + 2 + FW_BITS];
        fmt.upper_case  = beat[VB + RADIX_BITS + 3 + FW_BITS];
        // out-of-range radix clamps to the nearest legal base
        if (base < int'(RADIX_MIN))
            base = int'(RADIX_MIN);
        if (base > int'(RADIX_MAX))
            base = int'(RADIX_MAX);
        if (width > ITPA_MAX_WIDTH)
            width = ITPA_MAX_WIDTH;

        // digits come out least significant first; zero still yields one digit
        quot = beat[VB-1:0];
        ndig = 0;
        do
        begin
            digits[ndig] = digit_to_ascii(int'(quot % base), fmt.upper_case);
            ndig++;
            quot = quot / base;
        end
        while (quot != 0 && ndig < VB);

        total = ndig + (fmt.negative ? 1 : 0);
        if (width > total)
            total = width;
        pad = total - ndig - (fmt.negative ? 1 : 0);

        if (fmt.left_adjust)
        begin
            // left adjust ignores pad_zero: always trailing spaces
            if (fmt.negative)
                field_chars.push_back(CH_MINUS);
            for (k = ndig - 1; k >= 0; k--)
                field_chars.push_back(digits[k]);
            for (k = 0; k < pad; k++)
                field_chars.push_back(CH_SPACE);
        end
        else if (fmt.negative && fmt.pad_zero)
        begin
            // sign leads, zeros sit between sign and digits
            field_chars.push_back(CH_MINUS);
            for (k = 0; k < pad; k++)
                field_chars.push_back(CH_ZERO);
            for (k = ndig - 1; k >= 0; k--)
                field_chars.push_back(digits[k]);
        end
        else
        begin
            for (k = 0; k < pad; k++)
                field_chars.push_back(fmt.pad_zero ? CH_ZERO : CH_SPACE);
            if (fmt.negative)
                field_chars.push_back(CH_MINUS);
            for (k = ndig - 1; k >= 0; k--)
                field_chars.push_back(digits[k]);
        end

        for (k = 0; k < total; k++)
            expected_chars.push_back(char_beat_t'{field_chars[k], k == total - 1});
    endfunction

    always @(posedge clk)
    begin : watch
        char_beat_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                format_field(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                checked++;
                if (expected_chars.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected char beat: data=%02h last=%b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last)
                    begin
                        if (mismatches < 10)
                            $display("[%0t] char mismatch: exp data=%02h last=%b, got data=%02h last=%b",
                                     $realtime, want.ch, want.last, m_axis_tdata, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            waiting = expected_chars.size();
        end
    end

endmodule

// ===== sim/integer_to_padded_ascii_core_tb.sv =====
// Testbench top for integer_to_padded_ascii_core: clock, reset, request stimulus, verdict.
// Depends on itpa_pkg, the core RTL and ascii_field_checker.
module integer_to_padded_ascii_core_tb
    import itpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = ((ITPA_VALUE_BITS + IN_FIELD_BITS + 7) / 8) * 8;
    // worst item: 32 digits through the bit-serial divider plus 63 chars under heavy stall
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PER_PHASE = 83;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CHAR_BITS-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    int error_count;
    int pending_chars;
    int chars_checked;
    int src_idle_pct  = 27;
    int sink_idle_pct = 66;
    int requests_sent = 0;
    int directed_sent = 0;
    int cycle_count   = 0;

    integer_to_padded_ascii_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ascii_field_checker #(.DATA_W(DATA_W)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .error_count   (error_count),
        .pending_chars (pending_chars),
        .chars_checked (chars_checked)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sink backpressure: a fresh coin per cycle, so stalls land on every
    // phase of the character stream (first, middle, last beat).
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars still expected",
                     cycle_count, pending_chars);
            $display("integer_to_padded_ascii_core_tb: done, errors");
            $finish;
        end
    end

    // tdata layout, LSB up: value[31:0], radix[5:0], negative, field_width[5:0],
    // left_adjust, pad_zero, upper_case
    function automatic logic [DATA_W-1:0] pack_request(
        input logic [ITPA_VALUE_BITS-1:0] value,
        input logic [RADIX_BITS-1:0]      radix,
        input logic                       negative,
        input logic [FW_BITS-1:0]         field_width,
        input logic                       left_adjust,
        input logic                       pad_zero,
        input logic                       upper_case
    );
        return DATA_W'({upper_case, pad_zero, left_adjust, field_width, negative,
                        radix, value});
    endfunction

    // Random request biased toward realistic printf use, with a tail of
    // out-of-range radixes, wide fields and boundary values.
    function automatic logic [DATA_W-1:0] random_request();
        logic [ITPA_VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0]      radix;
        logic [FW_BITS-1:0]         width;
        case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom_range(0, 999);
            2: value = $urandom >> $urandom_range(0, 31);
            default:
                case ($urandom_range(0, 3))
                    0: value = '0;
                    1: value = '1;
                    2: value = 1;
                    default: value = 32'h8000_0000;
                endcase
        endcase
        case ($urandom_range(0, 9))
            0: radix = 6'd2;
            1: radix = 6'd8;
            2, 3: radix = DEC_BASE;
            4: radix = 6'd16;
            5: radix = 6'd36;
            6: radix = RADIX_BITS'($urandom_range(0, 63));   // includes clamped bases
            default: radix = RADIX_BITS'($urandom_range(2, 36));
        endcase
        if ($urandom_range(0, 3) == 0)
            width = FW_BITS'($urandom_range(0, 63));
        else
            width = FW_BITS'($urandom_range(0, 16));
        return pack_request(value, radix, 1'($urandom_range(0, 1)), width,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
    endfunction

    // One request beat; valid stays high across back-to-back beats.
    task automatic send_request(input logic [DATA_W-1:0] beat);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero, extremes, every radix edge, each padding mode
        send_request(pack_request('0, DEC_BASE, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request('1, 6'd2, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request('1, 6'd36, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(pack_request('1, 6'd36, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request(32'hDEAD_BEEF, 6'd16, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(pack_request(32'hDEAD_BEEF, 6'd16, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        // radix below 2 and above 36 clamp
        send_request(pack_request(32'd77, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request(32'd77, 6'd1, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request(32'd1295, 6'd37, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1));
        send_request(pack_request('1, 6'd63, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0));
        // sign with zero padding: minus, zeros, digits
        send_request(pack_request(32'd1234, DEC_BASE, 1'b1, 6'd12, 1'b0, 1'b1, 1'b0));
        // left adjust with pad_zero set still pads with spaces
        send_request(pack_request(32'd1234, DEC_BASE, 1'b1, 6'd10, 1'b1, 1'b1, 1'b0));
        send_request(pack_request(32'd42, DEC_BASE, 1'b1, 6'd8, 1'b0, 1'b0, 1'b0));
        send_request(pack_request(32'd42, DEC_BASE, 1'b0, 6'd8, 1'b0, 1'b1, 1'b0));
        // widest fields
        send_request(pack_request(32'd9, DEC_BASE, 1'b0, 6'd63, 1'b0, 1'b0, 1'b0));
        send_request(pack_request(32'hABC, 6'd16, 1'b1, 6'd63, 1'b1, 1'b0, 1'b1));
        send_request(pack_request('1, 6'd2, 1'b1, 6'd63, 1'b0, 1'b1, 1'b1));
        // width narrower than the number: no truncation
        send_request(pack_request(32'd123456, DEC_BASE, 1'b1, 6'd3, 1'b0, 1'b1, 1'b0));
        send_request(pack_request(32'd1, 6'd2, 1'b0, 6'd0, 1'b1, 1'b0, 1'b0));
        send_request(pack_request('0, DEC_BASE, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0));
        send_request(pack_request('1, 6'd2, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1));
        send_request(pack_request(32'h8000_0000, 6'd8, 1'b0, 6'd1, 1'b0, 1'b1, 1'b0));
        directed_sent = requests_sent;

        // Random, three stall mixes
        repeat (RANDOM_PER_PHASE) send_request(random_request());
        set_idling(66, 27);
        repeat (RANDOM_PER_PHASE) send_request(random_request());
        set_idling(0, 0);
        repeat (RANDOM_PER_PHASE) send_request(random_request());

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_chars != 0)
            @(negedge clk);
        // drain window: catch any stray beats after the last expected one
        repeat (50) @(negedge clk);

        $display("%0d requests (%0d directed, rest random over three stall mixes)",
                 requests_sent, directed_sent);
        $display("%0d char beats checked, %0d mismatches, %0d chars outstanding",
                 chars_checked, error_count, pending_chars);
        if (error_count == 0 && pending_chars == 0)
            $display("integer_to_padded_ascii_core_tb: done, clean");
        else
            $display("integer_to_padded_ascii_core_tb: done, errors");
        $finish;
    end

endmodule
